@@ hdl/cipc_pkg.sv @@
// Package: phase codes, status/sense bits, parity helper, command checks.
`default_nettype none
package cipc_pkg;

  typedef enum logic [12:0] {
    P_IDLE          = 13'b0000000000001,
    P_INIT_SEL      = 13'b0000000000010,
    P_COMMAND       = 13'b0000000000100,
    P_STATUS        = 13'b0000000001000,
    P_STATUS_ACCEPT = 13'b0000000010000,
    P_STATUS_WAIT   = 13'b0000000100000,
    P_BUSY          = 13'b0000001000000,
    P_END_STATUS    = 13'b0000010000000,
    P_END_ACCEPT    = 13'b0000100000000,
    P_WAIT_DEVEND   = 13'b0001000000000,
    P_OPR           = 13'b0010000000000,
    P_DATA1         = 13'b0100000000000,
    P_DATA2         = 13'b1000000000000
  } phase_t;

  localparam logic [7:0] ST_BSY = 8'h10;
  localparam logic [7:0] ST_CE  = 8'h08;
  localparam logic [7:0] ST_DE  = 8'h04;
  localparam logic [7:0] ST_UC  = 8'h02;
  localparam logic [7:0] ST_UE  = 8'h01;
  localparam logic [7:0] SN_REJ = 8'h80;
  localparam logic [7:0] SN_INT = 8'h40;
  localparam logic [7:0] SN_BUS = 8'h20;
  localparam logic [7:0] SN_CH9 = 8'h01;
  localparam logic [7:0] CMD_NOP   = 8'h03;
  localparam logic [7:0] CMD_SENSE = 8'h04;
  localparam logic [0:0] REG_ADDR  = 1'b0;
  localparam logic [0:0] REG_READY = 1'b1;

  // command class, low three bits of the command byte
  localparam logic [2:0] CM_TEST  = 3'd0;
  localparam logic [2:0] CM_WRITE = 3'd1;
  localparam logic [2:0] CM_CTRL  = 3'd3;
  localparam logic [2:0] CM_SENSE = 3'd4;

  // in-tag bit positions
  localparam int T_OPR = 0;
  localparam int T_ADR = 1;
  localparam int T_SRV = 2;
  localparam int T_STA = 3;
  localparam int T_REQ = 4;

  typedef struct packed {
    logic       opr, sup, sel, adr, cmd, srv, hld, other;
    logic [8:0] bus;
    logic       done, h9, h12;
  } word_in_t;

  typedef struct packed {
    logic [4:0] tags;
    logic       pass;
    logic [8:0] bus_in;
    logic       strobe;
    logic [7:0] dbyte;
    logic       start;
    logic [7:0] start_cmd;
  } word_out_t;

  function automatic logic [8:0] with_parity(input logic [7:0] v);
    return {~(^v), v};
  endfunction

  function automatic logic parity_bad(input logic [8:0] b);
    return ~(^b);
  endfunction

  function automatic logic bad_motion(input logic [7:0] c);
    logic [7:0] m;
    m = c & 8'h78;
    if (c[7]) return (m == 8'h00) || (m > 8'h60);
    return m > 8'h18;
  endfunction

endpackage
`default_nettype wire

@@ hdl/cipc_core.sv @@
// Per-word next-state logic of the channel handshake.
`default_nettype none
module cipc_core #(
  parameter int LINE_WIDTH = 132
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              load,
  input  cipc_pkg::word_in_t w,
  input  wire  [7:0]       unit_address,
  input  wire              device_ready,
  output cipc_pkg::word_out_t res
);
  import cipc_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] status_reg, status_next, sense_reg, sense_next, command_reg, command_next;
  logic [7:0] column_count, column_next;
  logic [4:0] tags_reg, tags;
  logic       fin, fin_next, busy, busy_next, req, req_next, stk, stk_next;
  logic       sel_f, sel_next, c9, c9_next, c12, c12_next;
  logic       pass, strobe, start, pending, wr;
  logic [8:0] bus_in;
  logic [7:0] dbyte, start_cmd, c;

  localparam logic [7:0] LW = 8'(LINE_WIDTH);

  always_comb begin
    phase_next = phase; status_next = status_reg; sense_next = sense_reg;
    command_next = command_reg; column_next = column_count; tags = tags_reg;
    fin_next = fin; busy_next = busy; req_next = req; stk_next = stk;
    sel_next = sel_f; c9_next = c9; c12_next = c12;
    pass = w.sel; strobe = 1'b0; start = 1'b0; start_cmd = 8'h00;
    bus_in = 9'h000; dbyte = 8'h00; pending = 1'b0; c = w.bus[7:0];
    wr = command_reg[1:0] == 2'b01;
    if (w.done) begin
      req_next = 1'b1; busy_next = 1'b0; fin_next = 1'b1;
      status_next = status_next | ST_DE;
      c9_next = w.h9 & wr; c12_next = w.h12 & wr;
      if (w.h9 && wr) begin
        sense_next = sense_next | SN_CH9; status_next = status_next | ST_UC;
      end
      if (w.h12 && wr) status_next = status_next | ST_UE;
    end
    if (!w.opr && !w.sup) begin
      tags[3:0] = 4'b0000; sel_next = 1'b0; req_next = 1'b0; phase_next = P_IDLE;
      status_next = '0; sense_next = '0; command_next = '0;
      fin_next = 1'b0; busy_next = 1'b0;
    end else begin
      if (phase != P_IDLE) pass = 1'b0;
      pending = req_next | stk;
      unique case (phase)
        P_INIT_SEL: begin
          bus_in = with_parity(unit_address);
          if (!w.adr) begin tags[T_ADR] = 1'b1; phase_next = P_COMMAND; end
        end
        P_COMMAND: begin
          req_next = 1'b0;
          bus_in = with_parity(unit_address);
          if (w.cmd) begin
            tags[T_ADR] = 1'b0; phase_next = P_STATUS;
            if (parity_bad(w.bus)) begin
              command_next = '0; fin_next = 1'b0; busy_next = 1'b0;
              status_next = ST_CE | ST_DE | ST_UC; sense_next = sense_next | SN_BUS;
            end else if (!stk && command_reg == 8'h00) begin
              status_next = '0;
              if (!device_ready) sense_next = sense_next | SN_INT;
              else sense_next = sense_next & ~SN_INT;
              unique case (c[2:0])
                CM_TEST: if (sense_next != 8'h00) status_next = ST_UC;
                CM_WRITE: begin
                  command_next = c; fin_next = 1'b0;
                  sense_next = sense_next & SN_INT;
                  if (bad_motion(c)) begin
                    sense_next = sense_next | SN_REJ;
                    status_next = ST_CE | ST_DE | ST_UC; fin_next = 1'b1;
                  end else if (sense_next[6]) begin
                    status_next = ST_CE | ST_DE | ST_UC; fin_next = 1'b1;
                  end else begin
                    c9_next = 1'b0; c12_next = 1'b0; column_next = '0; busy_next = 1'b1;
                  end
                end
                CM_CTRL: begin
                  command_next = c; fin_next = 1'b1;
                  sense_next = sense_next & SN_INT;
                  if (c == CMD_NOP) begin
                    command_next = '0; status_next = ST_CE | ST_DE;
                  end else if (bad_motion(c)) begin
                    sense_next = SN_REJ; status_next = ST_CE | ST_DE | ST_UC;
                  end else if (sense_next[6]) begin
                    status_next = ST_CE | ST_DE | ST_UC;
                  end else begin
                    c9_next = 1'b0; c12_next = 1'b0; status_next = ST_CE;
                    column_next = '0; fin_next = 1'b0; busy_next = 1'b1;
                    start = 1'b1; start_cmd = c;
                  end
                end
                CM_SENSE: begin
                  if (c != CMD_SENSE) begin
                    sense_next = SN_REJ; status_next = ST_CE | ST_DE | ST_UC;
                    fin_next = 1'b1;
                  end else begin
                    command_next = c; fin_next = 1'b0; busy_next = 1'b1;
                  end
                end
                default: begin
                  sense_next = SN_REJ; status_next = ST_CE | ST_DE | ST_UC;
                end
              endcase
            end
          end else if (w.adr && !w.hld) begin
            tags[T_ADR] = 1'b0; tags[T_OPR] = 1'b0;
            status_next = status_next | ST_CE;
            if (wr) begin
              status_next = status_next | ST_DE;
              if (sense_next != 8'h00) status_next = status_next | ST_UC;
              fin_next = 1'b1; busy_next = 1'b0; command_next = '0;
            end
            phase_next = P_STATUS_WAIT;
          end
        end
        P_STATUS: begin
          tags[T_ADR] = 1'b0; bus_in = with_parity(status_next);
          tags[T_STA] = 1'b1; phase_next = P_STATUS_ACCEPT;
        end
        P_STATUS_ACCEPT: begin
          bus_in = with_parity(status_next);
          if (w.cmd) begin
            stk_next = 1'b1; phase_next = P_STATUS_WAIT;
            tags[T_OPR] = 1'b0; tags[T_STA] = 1'b0;
          end else if (w.srv) begin
            tags[T_STA] = 1'b0;
            if (status_next[3]) begin
              status_next = '0; phase_next = P_STATUS_WAIT;
              if (fin_next) begin
                stk_next = 1'b0; command_next = '0; fin_next = 1'b0; busy_next = 1'b0;
              end
            end else begin
              status_next = '0;
              if (fin_next || command_reg == 8'h00) begin
                tags[T_OPR] = 1'b0; stk_next = 1'b0; command_next = '0;
                fin_next = 1'b0; busy_next = 1'b0; phase_next = P_IDLE;
              end else phase_next = P_OPR;
            end
          end else if (w.adr) begin
            phase_next = P_IDLE; tags[T_OPR] = 1'b0; tags[T_STA] = 1'b0;
          end
        end
        P_STATUS_WAIT: begin
          if (!w.cmd && !w.srv && !w.adr) begin
            if (!w.hld) begin
              sel_next = 1'b0; tags[T_OPR] = 1'b0; phase_next = P_IDLE;
            end else phase_next = P_WAIT_DEVEND;
          end
        end
        P_BUSY: begin
          bus_in = with_parity(ST_BSY);
          if (!w.sel) begin
            tags[T_STA] = 1'b0; sel_next = 1'b0; phase_next = P_IDLE;
            if (w.adr) begin
              status_next = status_next | ST_CE;
              if (wr) begin
                status_next = status_next | ST_DE;
                if (sense_next != 8'h00) status_next = status_next | ST_UC;
                fin_next = 1'b1; busy_next = 1'b0; command_next = '0;
              end
            end
          end
        end
        P_END_STATUS: begin
          if (!(w.cmd || w.srv)) begin
            bus_in = with_parity(status_next);
            tags[T_STA] = 1'b1; phase_next = P_END_ACCEPT;
          end
        end
        P_END_ACCEPT: begin
          bus_in = with_parity(status_next);
          if (w.cmd) begin
            stk_next = 1'b1; phase_next = P_STATUS_WAIT;
            tags[T_STA] = 1'b0; tags[T_OPR] = 1'b0;
          end else if (w.srv) begin
            status_next = '0;
            tags[T_STA] = 1'b0;
            if (fin_next) begin
              tags[T_OPR] = 1'b0; stk_next = 1'b0; command_next = '0;
              fin_next = 1'b0; busy_next = 1'b0;
            end
            phase_next = P_STATUS_WAIT;
          end
        end
        P_WAIT_DEVEND: begin
          if (fin_next) begin req_next = 1'b0; phase_next = P_STATUS; end
        end
        P_OPR: begin
          req_next = 1'b0;
          if (w.adr) begin
            status_next = status_next | ST_CE;
            if (wr) begin
              status_next = status_next | ST_DE;
              if (sense_next != 8'h00) status_next = status_next | ST_UC;
              fin_next = 1'b1; busy_next = 1'b0; command_next = '0;
            end
          end else if (command_reg == CMD_SENSE || column_count < LW) begin
            phase_next = P_DATA1;
          end else begin
            start = 1'b1; start_cmd = command_reg;
            status_next = status_next | ST_CE; phase_next = P_END_STATUS;
          end
        end
        P_DATA1: begin
          if (!(w.srv || w.sup)) begin
            tags[T_SRV] = 1'b1;
            bus_in = (command_reg == CMD_SENSE) ? with_parity(sense_next) : 9'h100;
            phase_next = P_DATA2;
          end
        end
        P_DATA2: begin
          bus_in = (command_reg == CMD_SENSE) ? with_parity(sense_next) : 9'h100;
          if (w.srv || w.cmd) begin
            tags[T_SRV] = 1'b0;
            if (w.srv) begin
              if (command_reg[0]) begin
                if (parity_bad(w.bus)) begin
                  sense_next = sense_next | SN_BUS;
                  status_next = status_next | ST_UC | ST_CE | ST_DE;
                  busy_next = 1'b0; fin_next = 1'b1; phase_next = P_END_STATUS;
                end else begin
                  strobe = 1'b1; dbyte = c; column_next = column_count + 8'd1;
                  phase_next = P_OPR;
                end
              end
              if (command_reg == CMD_SENSE) begin
                status_next = status_next | ST_CE | ST_DE; fin_next = 1'b1;
                phase_next = P_END_STATUS;
              end
            end
            if (w.cmd) begin
              start = 1'b1; start_cmd = command_reg;
              status_next = status_next | ST_CE; phase_next = P_END_STATUS;
            end
          end
        end
        default: begin
          phase_next = P_IDLE;
          if (w.opr) begin
            if (w.other || tags[T_OPR]) begin
              if (pending) tags[T_REQ] = 1'b0;
            end else begin
              if (pending) tags[T_REQ] = !w.sup && !w.adr;
              if (w.sel) begin
                if (w.adr) begin
                  if (c == unit_address) begin
                    pass = 1'b0; tags[T_REQ] = 1'b0;
                    if (parity_bad(w.bus)) sense_next = sense_next | SN_BUS;
                    if (busy_next) begin
                      bus_in = with_parity(ST_BSY); tags[T_STA] = 1'b1;
                      phase_next = P_BUSY;
                    end else begin
                      tags[T_OPR] = 1'b1; bus_in = with_parity(unit_address);
                      phase_next = P_INIT_SEL; sel_next = 1'b1;
                    end
                  end
                end else if (!w.sup && pending) begin
                  pass = 1'b0; tags[T_REQ] = 1'b0; tags[T_OPR] = 1'b1;
                  bus_in = with_parity(unit_address); sel_next = 1'b1;
                  phase_next = P_INIT_SEL;
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; status_reg <= '0; sense_reg <= '0; command_reg <= '0;
      column_count <= '0; tags_reg <= '0; fin <= 1'b0; busy <= 1'b0; req <= 1'b0;
      stk <= 1'b0; sel_f <= 1'b0; c9 <= 1'b0; c12 <= 1'b0;
    end else if (load) begin
      phase <= phase_next; status_reg <= status_next; sense_reg <= sense_next;
      command_reg <= command_next; column_count <= column_next; tags_reg <= tags;
      fin <= fin_next; busy <= busy_next; req <= req_next; stk <= stk_next;
      sel_f <= sel_next; c9 <= c9_next; c12 <= c12_next;
    end
  end

  assign res = '{tags: tags, pass: pass, bus_in: bus_in, strobe: strobe, dbyte: dbyte,
                 start: start, start_cmd: start_cmd};
endmodule
`default_nettype wire

@@ hdl/channel_interface_printer_control_unit.sv @@
// Top level: input word register, handshake core, output register.
// An accepted word waits in the input register; its result goes to the output register.
// Throughput: one word per cycle when out_ready does not hold the output register;
// input and output registers are decoupled, the core state advances on each load.
// Reset (rst, synchronous): phase idle, all status, sense, flags and tags cleared,
// config registers cleared, both channels empty.
`default_nettype none
module channel_interface_printer_control_unit #(
  parameter int LINE_WIDTH = 132
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire  [0:0] cfg_index,
  input  wire  [7:0] cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        opr_out, sup_out, sel_out, adr_out, cmd_out, srv_out, hld_out,
  input  wire        other_opr_in,
  input  wire  [8:0] bus_out,
  input  wire        print_done, chan9_hit, chan12_hit,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       opr_in, adr_in, srv_in, sta_in, req_in, sel_out_pass,
  output logic [8:0] bus_in,
  output logic       data_strobe,
  output logic [7:0] data_byte,
  output logic       print_start,
  output logic [7:0] print_command
);
  import cipc_pkg::*;

  logic [7:0] unit_address;
  logic       device_ready, w_valid, load;
  word_in_t   w;
  word_out_t  res, r;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_address <= '0; device_ready <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ADDR) unit_address <= cfg_data;
      else if (cfg_index == REG_READY) device_ready <= cfg_data[0];
    end
  end

  // core result moves into the output register when it is free
  assign load = w_valid && (!out_valid || out_ready);
  assign in_ready = !w_valid || load;

  always_ff @(posedge clk) begin
    if (rst) w_valid <= 1'b0;
    else if (in_ready) w_valid <= in_valid;
    if (in_valid && in_ready)
      w <= '{opr: opr_out, sup: sup_out, sel: sel_out, adr: adr_out, cmd: cmd_out,
             srv: srv_out, hld: hld_out, other: other_opr_in, bus: bus_out,
             done: print_done, h9: chan9_hit, h12: chan12_hit};
  end

  cipc_core #(.LINE_WIDTH(LINE_WIDTH)) u_core (
    .clk(clk), .rst(rst), .load(load), .w(w), .unit_address(unit_address),
    .device_ready(device_ready), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (load) r <= res;
  end

  assign opr_in = r.tags[T_OPR];
  assign adr_in = r.tags[T_ADR];
  assign srv_in = r.tags[T_SRV];
  assign sta_in = r.tags[T_STA];
  assign req_in = r.tags[T_REQ];
  assign sel_out_pass = r.pass;
  assign bus_in = r.bus_in;
  assign data_strobe = r.strobe;
  assign data_byte = r.dbyte;
  assign print_start = r.start;
  assign print_command = r.start_cmd;

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid) else $error("result lost");
  a_strobe_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !data_strobe) |-> data_byte == 8'h00) else $error("stray byte");
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !print_start) |-> print_command == 8'h00) else $error("stray cmd");
endmodule
`default_nettype wire

@@ sim/channel_interface_printer_control_unit_test.sv @@
// Testbench for the printer control unit: channel tag sequences checked against a local predictor.
`timescale 1ns / 1ps
module channel_interface_printer_control_unit_test;
  import cipc_pkg::*;

  localparam int LINE_LEN = 132;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_ADDR;
  logic [7:0] cfg_data = 8'h00;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  word_in_t cur = '0;

  logic opr_in, adr_in, srv_in, sta_in, req_in, sel_out_pass;
  logic [8:0] bus_in;
  logic data_strobe, print_start;
  logic [7:0] data_byte, print_command;

  always #10 clk = ~clk;

  channel_interface_printer_control_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opr_out(cur.opr), .sup_out(cur.sup), .sel_out(cur.sel), .adr_out(cur.adr),
    .cmd_out(cur.cmd), .srv_out(cur.srv), .hld_out(cur.hld), .other_opr_in(cur.other),
    .bus_out(cur.bus), .print_done(cur.done), .chan9_hit(cur.h9), .chan12_hit(cur.h12),
    .out_valid(out_valid), .out_ready(out_ready),
    .opr_in(opr_in), .adr_in(adr_in), .srv_in(srv_in), .sta_in(sta_in), .req_in(req_in),
    .sel_out_pass(sel_out_pass), .bus_in(bus_in), .data_strobe(data_strobe),
    .data_byte(data_byte), .print_start(print_start), .print_command(print_command)
  );

  word_in_t tag_samples[$];
  word_out_t expected_replies[$];
  int errors = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  int stall_req = 0, stall_ack = 0, stall_left = 0;

  // device model state
  phase_t dev_phase;
  logic [7:0] dev_status, dev_sense, dev_cmd, dev_col, cfg_addr;
  logic [4:0] dev_tags;
  logic dev_fin, dev_busy, dev_req, dev_stacked, dev_sel, hit9, hit12, cfg_ready;
  logic start_now;
  logic [7:0] start_byte;

  function automatic logic [8:0] odd_byte(input logic [7:0] v);
    return {~(^v), v};
  endfunction

  function automatic logic parity_wrong(input logic [8:0] b);
    return (^b) == 1'b0;
  endfunction

  function automatic logic motion_invalid(input logic [7:0] c);
    logic [7:0] m;
    m = c & 8'h78;
    if (c[7]) return (m == 8'h00) || (m > 8'h60);
    return m > 8'h18;
  endfunction

  task automatic halt_device();
    dev_status |= ST_CE;
    if (dev_cmd[1:0] == 2'b01) begin
      dev_status |= ST_DE;
      if (dev_sense != 8'h00) dev_status |= ST_UC;
      dev_fin = 1'b1;
      dev_busy = 1'b0;
      dev_cmd = 8'h00;
    end
  endtask

  task automatic decode_command(input logic [7:0] c);
    dev_status = 8'h00;
    if (!cfg_ready) dev_sense |= SN_INT; else dev_sense &= ~SN_INT;
    case (c[2:0])
      CM_TEST: if (dev_sense != 8'h00) dev_status |= ST_UC;
      CM_WRITE: begin
        dev_cmd = c; dev_fin = 1'b0; dev_sense &= SN_INT;
        if (motion_invalid(c)) begin
          dev_sense |= SN_REJ; dev_status = ST_CE | ST_DE | ST_UC; dev_fin = 1'b1;
        end else if (dev_sense & SN_INT) begin
          dev_status = ST_CE | ST_DE | ST_UC; dev_fin = 1'b1;
        end else begin
          hit9 = 1'b0; hit12 = 1'b0; dev_col = 8'h00; dev_busy = 1'b1;
        end
      end
      CM_CTRL: begin
        dev_cmd = c; dev_fin = 1'b1; dev_sense &= SN_INT;
        if (c == CMD_NOP) begin
          dev_cmd = 8'h00; dev_status = ST_CE | ST_DE;
        end else if (motion_invalid(c)) begin
          dev_sense = SN_REJ; dev_status = ST_CE | ST_DE | ST_UC;
        end else if (dev_sense & SN_INT) begin
          dev_status = ST_CE | ST_DE | ST_UC;
        end else begin
          hit9 = 1'b0; hit12 = 1'b0; dev_status = ST_CE; dev_col = 8'h00;
          dev_fin = 1'b0; dev_busy = 1'b1; start_now = 1'b1; start_byte = c;
        end
      end
      CM_SENSE: begin
        if (c != CMD_SENSE) begin
          dev_sense = SN_REJ; dev_status = ST_CE | ST_DE | ST_UC; dev_fin = 1'b1;
        end else begin
          dev_cmd = c; dev_fin = 1'b0; dev_busy = 1'b1;
        end
      end
      default: begin
        dev_sense = SN_REJ; dev_status = ST_CE | ST_DE | ST_UC;
      end
    endcase
  endtask

  task automatic channel_step(input word_in_t w, output word_out_t r);
    logic [4:0] tg;
    logic [8:0] bi;
    logic pass, stb, pend, wr;
    logic [7:0] db;
    tg = dev_tags; bi = 9'h000; pass = w.sel; stb = 1'b0; db = 8'h00;
    start_now = 1'b0; start_byte = 8'h00;
    // print completion is applied before the tags are looked at
    if (w.done) begin
      wr = (dev_cmd[1:0] == 2'b01);
      dev_req = 1'b1; dev_busy = 1'b0; dev_fin = 1'b1; dev_status |= ST_DE;
      hit9 = w.h9 && wr; hit12 = w.h12 && wr;
      if (hit9) begin dev_sense |= SN_CH9; dev_status |= ST_UC; end
      if (hit12) dev_status |= ST_UE;
    end
    if (!w.opr && !w.sup) begin
      tg[T_OPR] = 1'b0; tg[T_ADR] = 1'b0; tg[T_SRV] = 1'b0; tg[T_STA] = 1'b0;
      dev_sel = 1'b0; dev_req = 1'b0; dev_phase = P_IDLE; dev_status = 8'h00;
      dev_sense = 8'h00; dev_cmd = 8'h00; dev_fin = 1'b0; dev_busy = 1'b0;
    end else begin
      if (dev_phase != P_IDLE) pass = 1'b0;
      pend = dev_req || dev_stacked;
      case (dev_phase)
        P_INIT_SEL: begin
          bi = odd_byte(cfg_addr);
          if (!w.adr) begin tg[T_ADR] = 1'b1; dev_phase = P_COMMAND; end
        end
        P_COMMAND: begin
          dev_req = 1'b0;
          bi = odd_byte(cfg_addr);
          if (w.cmd) begin
            tg[T_ADR] = 1'b0; dev_phase = P_STATUS;
            if (parity_wrong(w.bus)) begin
              dev_cmd = 8'h00; dev_fin = 1'b0; dev_busy = 1'b0;
              dev_status = ST_CE | ST_DE | ST_UC; dev_sense |= SN_BUS;
            end else if (!dev_stacked && dev_cmd == 8'h00) begin
              decode_command(w.bus[7:0]);
            end
          end else if (w.adr && !w.hld) begin
            tg[T_ADR] = 1'b0; tg[T_OPR] = 1'b0;
            halt_device();
            dev_status |= ST_CE;
            dev_phase = P_STATUS_WAIT;
          end
        end
        P_STATUS: begin
          tg[T_ADR] = 1'b0;
          bi = odd_byte(dev_status);
          tg[T_STA] = 1'b1; dev_phase = P_STATUS_ACCEPT;
        end
        P_STATUS_ACCEPT: begin
          bi = odd_byte(dev_status);
          if (w.cmd) begin
            dev_stacked = 1'b1; dev_phase = P_STATUS_WAIT;
            tg[T_OPR] = 1'b0; tg[T_STA] = 1'b0;
          end else if (w.srv) begin
            tg[T_STA] = 1'b0;
            if (dev_status & ST_CE) begin
              dev_status = 8'h00; dev_phase = P_STATUS_WAIT;
              if (dev_fin) begin
                dev_stacked = 1'b0; dev_cmd = 8'h00; dev_fin = 1'b0; dev_busy = 1'b0;
              end
            end else begin
              dev_status = 8'h00;
              if (dev_fin || dev_cmd == 8'h00) begin
                tg[T_OPR] = 1'b0; dev_stacked = 1'b0; dev_cmd = 8'h00;
                dev_fin = 1'b0; dev_busy = 1'b0; dev_phase = P_IDLE;
              end else begin
                dev_phase = P_OPR;
              end
            end
          end else if (w.adr) begin
            dev_phase = P_IDLE; tg[T_OPR] = 1'b0; tg[T_STA] = 1'b0;
          end
        end
        P_STATUS_WAIT: begin
          if (!w.cmd && !w.srv && !w.adr) begin
            if (!w.hld) begin
              dev_sel = 1'b0; tg[T_OPR] = 1'b0; dev_phase = P_IDLE;
            end else begin
              dev_phase = P_WAIT_DEVEND;
            end
          end
        end
        P_BUSY: begin
          bi = odd_byte(ST_BSY);
          if (!w.sel) begin
            tg[T_STA] = 1'b0; dev_sel = 1'b0; dev_phase = P_IDLE;
            if (w.adr) halt_device();
          end
        end
        P_END_STATUS: begin
          if (!w.cmd && !w.srv) begin
            bi = odd_byte(dev_status);
            tg[T_STA] = 1'b1; dev_phase = P_END_ACCEPT;
          end
        end
        P_END_ACCEPT: begin
          bi = odd_byte(dev_status);
          if (w.cmd) begin
            dev_stacked = 1'b1; dev_phase = P_STATUS_WAIT;
            tg[T_STA] = 1'b0; tg[T_OPR] = 1'b0;
          end else if (w.srv) begin
            dev_status = 8'h00;
            tg[T_STA] = 1'b0;
            if (dev_fin) begin
              tg[T_OPR] = 1'b0; dev_stacked = 1'b0; dev_cmd = 8'h00;
              dev_fin = 1'b0; dev_busy = 1'b0;
            end
            dev_phase = P_STATUS_WAIT;
          end
        end
        P_WAIT_DEVEND: begin
          if (dev_fin) begin dev_req = 1'b0; dev_phase = P_STATUS; end
        end
        P_OPR: begin
          dev_req = 1'b0;
          if (w.adr) halt_device();
          else if (dev_cmd == CMD_SENSE || dev_col < LINE_LEN) dev_phase = P_DATA1;
          else begin
            start_now = 1'b1; start_byte = dev_cmd;
            dev_status |= ST_CE; dev_phase = P_END_STATUS;
          end
        end
        P_DATA1: begin
          if (!w.srv && !w.sup) begin
            tg[T_SRV] = 1'b1;
            bi = (dev_cmd == CMD_SENSE) ? odd_byte(dev_sense) : 9'h100;
            dev_phase = P_DATA2;
          end
        end
        P_DATA2: begin
          bi = (dev_cmd == CMD_SENSE) ? odd_byte(dev_sense) : 9'h100;
          if (w.srv || w.cmd) begin
            tg[T_SRV] = 1'b0;
            if (w.srv) begin
              if (dev_cmd[0]) begin
                if (parity_wrong(w.bus)) begin
                  dev_sense |= SN_BUS; dev_status |= ST_UC | ST_CE | ST_DE;
                  dev_busy = 1'b0; dev_fin = 1'b1; dev_phase = P_END_STATUS;
                end else begin
                  stb = 1'b1; db = w.bus[7:0]; dev_col = dev_col + 8'd1;
                  dev_phase = P_OPR;
                end
              end
              if (dev_cmd == CMD_SENSE) begin
                dev_status |= ST_CE | ST_DE; dev_fin = 1'b1; dev_phase = P_END_STATUS;
              end
            end
            if (w.cmd) begin
              start_now = 1'b1; start_byte = dev_cmd;
              dev_status |= ST_CE; dev_phase = P_END_STATUS;
            end
          end
        end
        default: begin
          // idle, and any unused phase code
          dev_phase = P_IDLE;
          if (w.opr) begin
            if (w.other || tg[T_OPR]) begin
              if (pend) tg[T_REQ] = 1'b0;
            end else begin
              if (pend) tg[T_REQ] = !w.sup && !w.adr;
              if (w.sel) begin
                if (w.adr) begin
                  if (w.bus[7:0] == cfg_addr) begin
                    pass = 1'b0; tg[T_REQ] = 1'b0;
                    if (parity_wrong(w.bus)) dev_sense |= SN_BUS;
                    if (dev_busy) begin
                      bi = odd_byte(ST_BSY); tg[T_STA] = 1'b1; dev_phase = P_BUSY;
                    end else begin
                      tg[T_OPR] = 1'b1; bi = odd_byte(cfg_addr);
                      dev_phase = P_INIT_SEL; dev_sel = 1'b1;
                    end
                  end
                end else if (!w.sup && pend) begin
                  pass = 1'b0; tg[T_REQ] = 1'b0; tg[T_OPR] = 1'b1;
                  bi = odd_byte(cfg_addr); dev_sel = 1'b1; dev_phase = P_INIT_SEL;
                end
              end
            end
          end
        end
      endcase
    end
    dev_tags = tg;
    r.tags = tg; r.pass = pass; r.bus_in = bi; r.strobe = stb; r.dbyte = db;
    r.start = start_now; r.start_cmd = start_now ? start_byte : 8'h00;
  endtask

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tag_samples.size() > 0 && (no_gaps || $urandom_range(99) >= 21)) begin
        cur <= tag_samples.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      stall_left <= 400;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= 21);
    end
  end

  // monitor and prediction
  always @(posedge clk) begin
    word_out_t e, r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply word with nothing expected");
          errors++;
        end else begin
          e = expected_replies.pop_front();
          check_field("opr_in", 9'(e.tags[T_OPR]), 9'(opr_in));
          check_field("adr_in", 9'(e.tags[T_ADR]), 9'(adr_in));
          check_field("srv_in", 9'(e.tags[T_SRV]), 9'(srv_in));
          check_field("sta_in", 9'(e.tags[T_STA]), 9'(sta_in));
          check_field("req_in", 9'(e.tags[T_REQ]), 9'(req_in));
          check_field("sel_out_pass", 9'(e.pass), 9'(sel_out_pass));
          check_field("bus_in", e.bus_in, bus_in);
          check_field("data_strobe", 9'(e.strobe), 9'(data_strobe));
          check_field("data_byte", 9'(e.dbyte), 9'(data_byte));
          check_field("print_start", 9'(e.start), 9'(print_start));
          check_field("print_command", 9'(e.start_cmd), 9'(print_command));
        end
      end
      if (in_valid && in_ready) begin
        channel_step(cur, r);
        expected_replies.push_back(r);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic word_in_t tw(input bit opr, sup, sel, adr, cmd, srv,
                                  input logic [8:0] bus);
    word_in_t w;
    w = '0;
    w.opr = opr; w.sup = sup; w.sel = sel; w.adr = adr; w.cmd = cmd; w.srv = srv;
    w.bus = bus;
    return w;
  endfunction

  task automatic wait_drained();
    while (tag_samples.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] a, input logic r);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= REG_ADDR; cfg_data <= a;
    @(posedge clk);
    cfg_index <= REG_READY; cfg_data <= {7'd0, r};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_addr = a; cfg_ready = r;
  endtask

  // select, command, status, data words, optional stop and print completion
  task automatic transaction(input logic [7:0] c, input int nbytes, input bit bad_par,
                             input bit halt, input bit finish);
    word_in_t w;
    tag_samples.push_back(tw(1, 0, 1, 1, 0, 0, odd_byte(cfg_addr)));
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
    if (halt) begin
      tag_samples.push_back(tw(1, 0, 0, 1, 0, 0, 9'h000));
    end else begin
      w = tw(1, 0, 0, 0, 1, 0, odd_byte(c));
      if (bad_par) w.bus[8] = ~w.bus[8];
      tag_samples.push_back(w);
    end
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 1, 9'h000));
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
    for (int i = 0; i < nbytes; i++) begin
      tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
      w = tw(1, 0, 0, 0, 0, 1, odd_byte(8'($urandom_range(255))));
      if ($urandom_range(40) == 0) w.bus[8] = ~w.bus[8];
      tag_samples.push_back(w);
    end
    if (nbytes > 0 && $urandom_range(1) != 0) begin
      tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
      tag_samples.push_back(tw(1, 0, 0, 0, 1, 0, 9'h000));
    end
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 1, 9'h000));
    tag_samples.push_back(tw(1, 0, 0, 0, 0, 0, 9'h000));
    if (finish) begin
      w = tw(1, 0, 0, 0, 0, 0, 9'h000);
      w.done = 1'b1; w.h9 = 1'($urandom_range(1)); w.h12 = 1'($urandom_range(1));
      tag_samples.push_back(w);
      // poll the device for its ending status
      tag_samples.push_back(tw(1, 0, 1, 0, 0, 0, 9'h000));
      repeat (4) tag_samples.push_back(tw(1, 0, 0, 0, 0, 1'($urandom_range(1)), 9'h000));
    end
  endtask

  function automatic logic [7:0] random_command();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return CMD_NOP;
      2: return CMD_SENSE;
      3, 4: return (8'($urandom_range(1)) << 7) | 8'(8 * $urandom_range(3)) | 8'h01;
      5: return 8'(8 * $urandom_range(12)) | 8'h03;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    word_in_t w;
    int n;
    int n0;
    int next_cfg;
    logic [7:0] c;
    dev_phase = P_IDLE; dev_status = 0; dev_sense = 0; dev_cmd = 0; dev_col = 0;
    dev_tags = 0; dev_fin = 0; dev_busy = 0; dev_req = 0; dev_stacked = 0; dev_sel = 0;
    hit9 = 0; hit12 = 0; cfg_addr = 0; cfg_ready = 0; start_now = 0; start_byte = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: not ready gives intervention, address extremes, each command class
    transaction(8'h01, 0, 0, 0, 0);
    set_config(8'hFF, 1'b1);
    transaction(8'h00, 0, 0, 0, 0);
    transaction(CMD_NOP, 0, 0, 0, 0);
    transaction(8'h0B, 0, 0, 0, 1);
    transaction(8'h01, 3, 0, 0, 1);
    transaction(CMD_SENSE, 1, 0, 0, 0);
    transaction(8'h14, 0, 0, 0, 0);
    transaction(8'h02, 0, 0, 0, 0);
    transaction(8'h81, 0, 1, 0, 0);
    transaction(8'h89, 0, 0, 1, 0);
    tag_samples.push_back(tw(0, 0, 0, 0, 0, 0, 9'h000));
    set_config(8'h00, 1'b1);

    n = 0;
    next_cfg = 250;
    while (n < 880) begin
      if (n >= next_cfg) begin
        set_config(8'($urandom_range(255)), $urandom_range(3) != 0);
        next_cfg = next_cfg + 250;
      end
      n0 = tag_samples.size();
      if (n >= 300 && n < 420) no_gaps = 1'b1; else no_gaps = 1'b0;
      if (n >= 500 && stall_req == 0) begin
        // long receiver hold-off while words keep coming
        stall_req = 1;
        repeat (6) transaction(8'h01, 2, 0, 0, 1);
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          c = random_command();
          transaction(c, (c[1:0] == 2'b01) ? (($urandom_range(30) == 0) ? 134 :
                      int'($urandom_range(6))) : int'(c == CMD_SENSE),
                      $urandom_range(15) == 0, $urandom_range(15) == 0,
                      $urandom_range(1) != 0);
        end
        6: tag_samples.push_back(tw(0, 0, 0, 0, 0, 0, 9'h000));
        7: begin
          w = tw(1, 0, 1, 0, 0, 0, 9'h000);
          w.done = 1'($urandom_range(1)); w.h9 = 1'($urandom_range(1));
          w.h12 = 1'($urandom_range(1));
          tag_samples.push_back(w);
        end
        default: repeat ($urandom_range(1, 6)) begin
          w = 20'($urandom());
          w.opr = $urandom_range(5) != 0;
          w.done = $urandom_range(7) == 0;
          tag_samples.push_back(w);
        end
      endcase
      n = n + tag_samples.size() - n0;
      wait (tag_samples.size() < 64);
    end

    while (tag_samples.size() > 0 || in_valid) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
